/* hdl/gsr_pkg.sv */
// ----------------------------------------------------------------------------
// gsr_pkg: shared types and helpers of the glyph span renderer
// Item kinds, draw modes, font store geometry, memory request and mask helpers.
// ----------------------------------------------------------------------------
package gsr_pkg;

  localparam int GLYPH_COLS       = 8;
  localparam int ROWS_PER_GLYPH   = 16;
  localparam int NUM_GLYPHS       = 256;
  localparam int FONT_DEPTH       = NUM_GLYPHS * ROWS_PER_GLYPH;
  localparam int FONT_ADDR_W      = $clog2(FONT_DEPTH);
  localparam int ROW_IDX_W        = $clog2(ROWS_PER_GLYPH);
  localparam int COORD_W          = 11;
  localparam int MASK_W           = 32;
  localparam int COLOR_W          = 8;

  localparam int DEF_SCREEN_WIDTH  = 640;
  localparam int DEF_SCREEN_HEIGHT = 480;
  localparam int DEF_GLYPH_ROWS    = 16;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_DRAW = 1'b1
  } gsr_kind_e;

  typedef enum logic [1:0] {
    MODE_PLAIN  = 2'd0,
    MODE_CROP   = 2'd1,
    MODE_DOUBLE = 2'd2,
    MODE_QUAD   = 2'd3
  } gsr_mode_e;

  // Font store access request: one write or one read per cycle
  typedef struct packed {
    logic                   we;
    logic                   re;
    logic [FONT_ADDR_W-1:0] addr;
    logic [GLYPH_COLS-1:0]  wdata;
  } gsr_mem_req_t;

  // Font bit 7 is the leftmost pixel and lands on mask bit 0
  function automatic logic [GLYPH_COLS-1:0] gsr_mirror(logic [GLYPH_COLS-1:0] b);
    logic [GLYPH_COLS-1:0] m;
    for (int i = 0; i < GLYPH_COLS; i++) begin
      m[i] = b[GLYPH_COLS-1-i];
    end
    return m;
  endfunction

  // Repeat each pixel once, twice or four times depending on the mode
  function automatic logic [MASK_W-1:0] gsr_widen(logic [GLYPH_COLS-1:0] m, gsr_mode_e mode);
    logic [MASK_W-1:0] r;
    r = '0;
    for (int i = 0; i < GLYPH_COLS; i++) begin
      unique case (mode)
        MODE_DOUBLE: r[2*i +: 2] = {2{m[i]}};
        MODE_QUAD:   r[4*i +: 4] = {4{m[i]}};
        MODE_PLAIN,
        MODE_CROP:   r[i] = m[i];
      endcase
    end
    return r;
  endfunction

endpackage

/* hdl/gsr_if.sv */
// ----------------------------------------------------------------------------
// gsr_if: item and span channels of the glyph span renderer
// Valid/ready channels; a transaction moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface gsr_in_if import gsr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  gsr_kind_e                 kind;
  logic [7:0]                char_code;
  logic [ROW_IDX_W-1:0]      glyph_row;
  logic [GLYPH_COLS-1:0]     font_bits;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  gsr_mode_e                 mode;
  logic [COLOR_W-1:0]        fg_index;
  logic [COLOR_W-1:0]        bg_index;
  logic                      overwrite;

  modport source (output valid, kind, char_code, glyph_row, font_bits, pos_x, pos_y,
                  mode, fg_index, bg_index, overwrite, input ready);
  modport sink   (input valid, kind, char_code, glyph_row, font_bits, pos_x, pos_y,
                  mode, fg_index, bg_index, overwrite, output ready);
endinterface

interface gsr_out_if import gsr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] row_y;
  logic signed [COORD_W-1:0] start_x;
  logic [MASK_W-1:0]         fg_mask;
  logic [MASK_W-1:0]         bg_mask;
  logic [COLOR_W-1:0]        fg_value;
  logic [COLOR_W-1:0]        bg_value;
  logic                      last;

  modport source (output valid, row_y, start_x, fg_mask, bg_mask, fg_value, bg_value,
                  last, input ready);
  modport sink   (input valid, row_y, start_x, fg_mask, bg_mask, fg_value, bg_value,
                  last, output ready);
endinterface

/* hdl/gsr_font_mem.sv */
// ----------------------------------------------------------------------------
// gsr_font_mem: font store
// 256 glyphs of 16 row bytes, one port, read data registered and held
// until the next read.
// ----------------------------------------------------------------------------
module gsr_font_mem import gsr_pkg::*; (
  input  logic                  clk_i,
  input  gsr_mem_req_t          req_i,
  output logic [GLYPH_COLS-1:0] rdata_o
);

  logic [GLYPH_COLS-1:0] mem_q [FONT_DEPTH];
  logic [GLYPH_COLS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/glyph_span_renderer.sv */
// ----------------------------------------------------------------------------
// glyph_span_renderer: 8x16 bitmap font blitter producing row spans
// Loads font row bytes and renders characters as per-row pixel masks.
// ----------------------------------------------------------------------------
// Usage:
//   item_i carries load and draw transactions. A load writes one font row byte
//   and gives no span. A draw gives GLYPH_ROWS spans in plain and cropped
//   mode, 2*GLYPH_ROWS doubled and 4*GLYPH_ROWS quadrupled, top row first,
//   on span_o; last marks the final span of a character.
//   Acceptance of a draw issues the font store read of row 0; the first span
//   is then registered in the output register once that register is free.
//   After that, one span per cycle follows while span_o does not stall, paced
//   by one font store read per glyph row that is issued while the last span of
//   the previous row is produced; item_i.ready is high only between draws.
//   A stall on span_o holds the sequencer and the span in the output register.
//   Reset empties the output register and returns to idle; the font store is
//   not cleared, so only loaded glyphs may be drawn.
// ----------------------------------------------------------------------------
module glyph_span_renderer import gsr_pkg::*; #(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
  parameter int GLYPH_ROWS    = DEF_GLYPH_ROWS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  gsr_in_if.sink   item_i,
  gsr_out_if.source span_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StEmit = 1'b1;

  localparam logic [ROW_IDX_W-1:0] RowLastC = ROW_IDX_W'(GLYPH_ROWS - 1);
  localparam logic signed [COORD_W:0] ScrWidthC  = (COORD_W+1)'(SCREEN_WIDTH);
  localparam logic signed [COORD_W:0] ScrHeightC = (COORD_W+1)'(SCREEN_HEIGHT);

  logic                 state_q, state_d;
  logic [ROW_IDX_W-1:0] yy_q, yy_d;
  logic [1:0]           sub_q, sub_d;

  // draw context
  logic [7:0]                char_q;
  logic signed [COORD_W-1:0] px_q;
  logic signed [COORD_W:0]   row_q;
  gsr_mode_e                 mode_q;
  logic [COLOR_W-1:0]        fg_q, bg_q;
  logic                      ow_q;
  logic [GLYPH_COLS-1:0]     col_vis_q, col_vis_d;

  // output register
  logic                      out_valid_q;
  logic signed [COORD_W-1:0] row_y_q, start_x_q;
  logic [MASK_W-1:0]         fg_mask_q, bg_mask_q;
  logic [COLOR_W-1:0]        fg_value_q, bg_value_q;
  logic                      last_q;

  gsr_mem_req_t          mem_req;
  logic [GLYPH_COLS-1:0] font_row;

  logic in_fire, draw_fire, out_free, emit;
  logic sub_last, row_last;

  logic [MASK_W-1:0]  fm, full, vis, f_mask, b_mask;
  logic [COLOR_W-1:0] f_val, b_val;
  logic               row_vis;

  gsr_font_mem u_font_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (font_row)
  );

  assign item_i.ready = (state_q == StIdle);
  assign in_fire      = item_i.valid && item_i.ready;
  assign draw_fire    = in_fire && (item_i.kind == KIND_DRAW);
  assign out_free     = !out_valid_q || span_o.ready;
  assign emit         = (state_q == StEmit) && out_free;

  always_comb begin
    unique case (mode_q)
      MODE_DOUBLE: sub_last = (sub_q == 2'd1);
      MODE_QUAD:   sub_last = (sub_q == 2'd3);
      MODE_PLAIN,
      MODE_CROP:   sub_last = (sub_q == 2'd0);
    endcase
  end
  assign row_last = (yy_q == RowLastC);

  // Load writes here; a draw fetches row 0 on acceptance and the next row
  // while the last sub-row of the current one goes out.
  always_comb begin
    mem_req       = '0;
    mem_req.wdata = item_i.font_bits;
    if (in_fire && item_i.kind == KIND_LOAD) begin
      mem_req.we   = 1'b1;
      mem_req.addr = {item_i.char_code, item_i.glyph_row};
    end else if (draw_fire) begin
      mem_req.re   = 1'b1;
      mem_req.addr = {item_i.char_code, ROW_IDX_W'(0)};
    end else if (emit && sub_last && !row_last) begin
      mem_req.re   = 1'b1;
      mem_req.addr = {char_q, yy_q + ROW_IDX_W'(1)};
    end
  end

  always_comb begin
    state_d = state_q;
    yy_d    = yy_q;
    sub_d   = sub_q;
    if (draw_fire) begin
      state_d = StEmit;
      yy_d    = '0;
      sub_d   = '0;
    end else if (emit) begin
      if (sub_last) begin
        sub_d = '0;
        yy_d  = yy_q + ROW_IDX_W'(1);
        if (row_last) begin
          state_d = StIdle;
        end
      end else begin
        sub_d = sub_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      yy_q        <= '0;
      sub_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      yy_q    <= yy_d;
      sub_q   <= sub_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (span_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Column visibility for cropped mode depends only on pos_x
  always_comb begin
    logic signed [COORD_W:0] col;
    for (int xx = 0; xx < GLYPH_COLS; xx++) begin
      col = (COORD_W+1)'(item_i.pos_x) + (COORD_W+1)'(xx);
      col_vis_d[xx] = (col >= 0) && (col < ScrWidthC);
    end
  end

  always_ff @(posedge clk_i) begin
    if (draw_fire) begin
      char_q    <= item_i.char_code;
      px_q      <= item_i.pos_x;
      row_q     <= (COORD_W+1)'(item_i.pos_y);
      mode_q    <= item_i.mode;
      fg_q      <= item_i.fg_index;
      bg_q      <= item_i.bg_index;
      ow_q      <= item_i.overwrite;
      col_vis_q <= col_vis_d;
    end else if (emit) begin
      row_q <= row_q + (COORD_W+1)'(1);
    end
  end

  // Span of the current screen row
  always_comb begin
    fm      = gsr_widen(gsr_mirror(font_row), mode_q);
    full    = gsr_widen({GLYPH_COLS{1'b1}}, mode_q);
    row_vis = (row_q >= 0) && (row_q < ScrHeightC);
    vis     = {{(MASK_W-GLYPH_COLS){1'b0}}, row_vis ? col_vis_q : {GLYPH_COLS{1'b0}}};
    if (mode_q == MODE_QUAD) begin
      b_mask = '0;
      b_val  = '0;
      if (fg_q == '0) begin
        f_mask = '1;
        f_val  = '0;
      end else begin
        f_mask = fm;
        // upper two sub-rows take fg+2*row, lower two one more
        f_val  = COLOR_W'(fg_q + {yy_q, 1'b0} + COLOR_W'(sub_q[1]));
      end
    end else begin
      f_mask = fm;
      b_mask = ow_q ? (full & ~fm) : '0;
      if (mode_q == MODE_CROP) begin
        f_mask = f_mask & vis;
        b_mask = b_mask & vis;
      end
      f_val = fg_q;
      b_val = ow_q ? bg_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      row_y_q    <= row_q[COORD_W-1:0];
      start_x_q  <= px_q;
      fg_mask_q  <= f_mask;
      bg_mask_q  <= b_mask;
      fg_value_q <= f_val;
      bg_value_q <= b_val;
      last_q     <= sub_last && row_last;
    end
  end

  assign span_o.valid    = out_valid_q;
  assign span_o.row_y    = row_y_q;
  assign span_o.start_x  = start_x_q;
  assign span_o.fg_mask  = fg_mask_q;
  assign span_o.bg_mask  = bg_mask_q;
  assign span_o.fg_value = fg_value_q;
  assign span_o.bg_value = bg_value_q;
  assign span_o.last     = last_q;

  // A stalled output freezes the row and sub-row counters
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit && !out_free) |=> ($stable(yy_q) && $stable(sub_q)))
    else $error("sequencer advanced while the output register was full");

  // A draw starts at the top row
  a_draw_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    draw_fire |=> (state_q == StEmit && yy_q == '0 && sub_q == '0 && !item_i.ready))
    else $error("draw did not start at the first row");

  // The final span returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && sub_last && row_last) |=> (state_q == StIdle && span_o.valid && span_o.last))
    else $error("final span did not end the draw");

  // The font store is never read and written in the same cycle
  a_mem_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req.we && mem_req.re))
    else $error("font store read and write collide");

endmodule

/* bench/glyph_span_renderer_test.sv */
// ----------------------------------------------------------------------------
// glyph_span_renderer_test: self-checking bench for the glyph span renderer
// Preloads a few glyphs, walks a table of directed draws and loads, then runs
// random loads and draws with random idling on both channels. Every span is
// compared field by field with local font shadow spans, some pinned by hand.
// ----------------------------------------------------------------------------
module glyph_span_renderer_test;
  import gsr_pkg::*;

  localparam int SCR_W      = 640;
  localparam int SCR_H      = 480;
  localparam int GLYPH_ROWS = 16;
  localparam int RANDOM_ITEMS = 236;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int DRAIN_TAIL   = 40;
  localparam longint RUN_LIMIT = 64'd10_000_000;

  typedef struct packed {
    gsr_kind_e                 kind;
    logic [7:0]                code;
    logic [ROW_IDX_W-1:0]      row;
    logic [GLYPH_COLS-1:0]     bits;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    gsr_mode_e                 mode;
    logic [COLOR_W-1:0]        fg;
    logic [COLOR_W-1:0]        bg;
    logic                      ow;
  } glyph_item_t;

  // Fields that hold for every span of one draw, typed in by hand
  typedef struct packed {
    logic               on;
    logic [MASK_W-1:0]  fm;
    logic [MASK_W-1:0]  bm;
    logic [COLOR_W-1:0] fv;
    logic [COLOR_W-1:0] bv;
  } pin_t;

  typedef struct packed {
    glyph_item_t it;
    pin_t        pin;
  } dir_row_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] row_y;
    logic signed [COORD_W-1:0] start_x;
    logic [MASK_W-1:0]         fg_mask;
    logic [MASK_W-1:0]         bg_mask;
    logic [COLOR_W-1:0]        fg_value;
    logic [COLOR_W-1:0]        bg_value;
    logic                      last;
  } span_t;

  localparam pin_t NO_PIN = '0;

  localparam int DIR_LEN = 20;
  localparam dir_row_t DIR_TAB [DIR_LEN] = '{
    '{'{KIND_DRAW, 8'h55, 4'd0, 8'h00, 11'sd0, 11'sd0, MODE_PLAIN, 8'd1, 8'd2, 1'b0},
      NO_PIN},
    '{'{KIND_DRAW, 8'h55, 4'd0, 8'h00, 11'sd100, 11'sd50, MODE_PLAIN, 8'h80, 8'h7F, 1'b1},
      NO_PIN},
    '{'{KIND_DRAW, 8'hFF, 4'd0, 8'h00, 11'sd1023, 11'sd1023, MODE_PLAIN, 8'hFF, 8'hFF, 1'b1},
      '{1'b1, 32'h0000_00FF, 32'h0, 8'hFF, 8'hFF}},
    '{'{KIND_DRAW, 8'h00, 4'd0, 8'h00, -11'sd32, -11'sd64, MODE_DOUBLE, 8'd3, 8'd4, 1'b1},
      '{1'b1, 32'h0, 32'h0000_FFFF, 8'd3, 8'd4}},
    '{'{KIND_DRAW, 8'hAA, 4'd0, 8'h00, 11'sd633, 11'sd470, MODE_DOUBLE, 8'd5, 8'd6, 1'b0},
      NO_PIN},
    '{'{KIND_DRAW, 8'h55, 4'd0, 8'h00, 11'sd10, 11'sd20, MODE_QUAD, 8'd0, 8'hFF, 1'b1},
      '{1'b1, 32'hFFFF_FFFF, 32'h0, 8'd0, 8'd0}},
    '{'{KIND_DRAW, 8'hAA, 4'd0, 8'h00, -11'sd32, 11'sd1023, MODE_QUAD, 8'hFF, 8'd9, 1'b1},
      NO_PIN},
    '{'{KIND_DRAW, 8'hFF, 4'd0, 8'h00, 11'sd1023, -11'sd64, MODE_QUAD, 8'd1, 8'd0, 1'b0},
      NO_PIN},
    '{'{KIND_DRAW, 8'hAA, 4'd0, 8'h00, 11'sd100, -11'sd64, MODE_CROP, 8'd7, 8'd8, 1'b1},
      '{1'b1, 32'h0, 32'h0, 8'd7, 8'd8}},
    '{'{KIND_DRAW, 8'hFF, 4'd0, 8'h00, 11'sd100, 11'sd1023, MODE_CROP, 8'd7, 8'd8, 1'b0},
      '{1'b1, 32'h0, 32'h0, 8'd7, 8'd0}},
    '{'{KIND_DRAW, 8'hFF, 4'd0, 8'h00, -11'sd32, 11'sd100, MODE_CROP, 8'd1, 8'd2, 1'b1},
      '{1'b1, 32'h0, 32'h0, 8'd1, 8'd2}},
    '{'{KIND_DRAW, 8'hFF, 4'd0, 8'h00, 11'sd640, 11'sd100, MODE_CROP, 8'd3, 8'd4, 1'b1},
      '{1'b1, 32'h0, 32'h0, 8'd3, 8'd4}},
    '{'{KIND_DRAW, 8'hAA, 4'd0, 8'h00, -11'sd3, 11'sd470, MODE_CROP, 8'd11, 8'd12, 1'b1},
      NO_PIN},
    '{'{KIND_DRAW, 8'h55, 4'd0, 8'h00, 11'sd636, -11'sd5, MODE_CROP, 8'd13, 8'd14, 1'b1},
      NO_PIN},
    '{'{KIND_DRAW, 8'hFF, 4'd0, 8'h00, 11'sd0, 11'sd0, MODE_CROP, 8'd1, 8'd2, 1'b1},
      '{1'b1, 32'h0000_00FF, 32'h0, 8'd1, 8'd2}},
    '{'{KIND_LOAD, 8'h55, 4'd3, 8'hFF, 11'sd0, 11'sd0, MODE_PLAIN, 8'd0, 8'd0, 1'b0},
      NO_PIN},
    '{'{KIND_LOAD, 8'h55, 4'd15, 8'h00, 11'sd0, 11'sd0, MODE_PLAIN, 8'd0, 8'd0, 1'b0},
      NO_PIN},
    '{'{KIND_DRAW, 8'h55, 4'd0, 8'h00, -11'sd1, -11'sd1, MODE_PLAIN, 8'd0, 8'd0, 1'b1},
      NO_PIN},
    '{'{KIND_DRAW, 8'hAA, 4'd0, 8'h00, 11'sd1023, -11'sd64, MODE_PLAIN, 8'hFF, 8'd0, 1'b1},
      NO_PIN},
    '{'{KIND_DRAW, 8'h00, 4'd0, 8'h00, 11'sd1023, 11'sd1023, MODE_QUAD, 8'hF0, 8'd1, 1'b1},
      NO_PIN}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  gsr_in_if  item_if ();
  gsr_out_if span_if ();

  glyph_span_renderer #(
    .SCREEN_WIDTH  (SCR_W),
    .SCREEN_HEIGHT (SCR_H),
    .GLYPH_ROWS    (GLYPH_ROWS)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_if),
    .span_o (span_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [7:0] font_shadow [FONT_DEPTH];
  bit         row_loaded  [FONT_DEPTH];
  bit         glyph_ready [NUM_GLYPHS];
  logic [7:0] drawable_q [$];
  span_t      pending_spans [$];
  int         mismatch_cnt = 0;
  int         items_sent   = 0;
  bit         tx_burst     = 1'b0;

  // Render one draw from the font shadow into the queue of pending spans
  function automatic void render_glyph(input glyph_item_t it, input pin_t pin);
    int scale, total, n, yy, sub, i, j, row_i, px_i, fv_i;
    logic [7:0]        bits;
    logic [MASK_W-1:0] fm, full, vis;
    span_t             sp;
    scale = (it.mode == MODE_DOUBLE) ? 2 : (it.mode == MODE_QUAD) ? 4 : 1;
    total = GLYPH_ROWS * scale;
    n = 0;
    px_i = $signed(it.px);
    for (yy = 0; yy < GLYPH_ROWS; yy++) begin
      bits = font_shadow[{it.code, yy[3:0]}];
      fm   = '0;
      full = '0;
      for (i = 0; i < GLYPH_COLS; i++) begin
        for (j = 0; j < scale; j++) begin
          full[i*scale+j] = 1'b1;
          fm[i*scale+j]   = bits[GLYPH_COLS-1-i];
        end
      end
      for (sub = 0; sub < scale; sub++) begin
        row_i      = $signed(it.py) + yy * scale + sub;
        sp.row_y   = row_i[COORD_W-1:0];
        sp.start_x = it.px;
        sp.last    = (n == total - 1);
        if (it.mode == MODE_QUAD) begin
          sp.bg_mask  = '0;
          sp.bg_value = '0;
          if (it.fg == '0) begin
            sp.fg_mask  = '1;
            sp.fg_value = '0;
          end else begin
            // upper two sub-rows take fg+2*row, lower two one more
            fv_i        = it.fg + 2 * yy + ((sub >= 2) ? 1 : 0);
            sp.fg_mask  = fm;
            sp.fg_value = fv_i[COLOR_W-1:0];
          end
        end else begin
          sp.fg_mask  = fm;
          sp.bg_mask  = it.ow ? (full & ~fm) : '0;
          sp.fg_value = it.fg;
          sp.bg_value = it.ow ? it.bg : '0;
          if (it.mode == MODE_CROP) begin
            // clip on the unwrapped row, report the wrapped one
            vis = '0;
            if (row_i >= 0 && row_i < SCR_H) begin
              for (i = 0; i < GLYPH_COLS; i++) begin
                if (px_i + i >= 0 && px_i + i < SCR_W) vis[i] = 1'b1;
              end
            end
            sp.fg_mask &= vis;
            sp.bg_mask &= vis;
          end
        end
        if (pin.on) begin
          sp.fg_mask  = pin.fm;
          sp.bg_mask  = pin.bm;
          sp.fg_value = pin.fv;
          sp.bg_value = pin.bv;
        end
        pending_spans.push_back(sp);
        n++;
      end
    end
  endfunction

  function automatic glyph_item_t load_item(input logic [7:0] code,
                                            input logic [ROW_IDX_W-1:0] row,
                                            input logic [GLYPH_COLS-1:0] bits);
    glyph_item_t it;
    int          noise;
    noise   = $urandom;
    it.kind = KIND_LOAD;
    it.code = code;
    it.row  = row;
    it.bits = bits;
    it.px   = noise[10:0];
    it.py   = noise[21:11];
    it.mode = gsr_mode_e'(noise[23:22]);
    it.fg   = 8'($urandom_range(255));
    it.bg   = 8'($urandom_range(255));
    it.ow   = noise[24];
    return it;
  endfunction

  task automatic drive_fields(input glyph_item_t it);
    item_if.kind      <= it.kind;
    item_if.char_code <= it.code;
    item_if.glyph_row <= it.row;
    item_if.font_bits <= it.bits;
    item_if.pos_x     <= it.px;
    item_if.pos_y     <= it.py;
    item_if.mode      <= it.mode;
    item_if.fg_index  <= it.fg;
    item_if.bg_index  <= it.bg;
    item_if.overwrite <= it.ow;
  endtask

  // Offer one transaction after a random gap; update the shadow on acceptance
  task automatic send_item(input glyph_item_t it, input pin_t pin);
    int gap, r;
    bit complete;
    if (items_sent % 24 == 0) tx_burst = ($urandom_range(3) == 0);
    gap = tx_burst ? 0 : $urandom_range(8);
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    drive_fields(it);
    item_if.valid <= 1'b1;
    do @(posedge clk_i); while (!item_if.ready);
    items_sent++;
    if (it.kind == KIND_LOAD) begin
      font_shadow[{it.code, it.row}] = it.bits;
      row_loaded[{it.code, it.row}]  = 1'b1;
      complete = 1'b1;
      for (r = 0; r < GLYPH_ROWS; r++) begin
        if (!row_loaded[{it.code, r[3:0]}]) complete = 1'b0;
      end
      if (complete && !glyph_ready[it.code]) begin
        glyph_ready[it.code] = 1'b1;
        drawable_q.push_back(it.code);
      end
    end else begin
      render_glyph(it, pin);
    end
    @(negedge clk_i);
  endtask

  task automatic cmp(input string fld, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, fld, want, got);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk_i) begin : span_check
    span_t want;
    if (rst_ni && span_if.valid && span_if.ready) begin
      if (pending_spans.size() == 0) begin
        $display("%0t: unexpected span, row_y %0d start_x %0d", $time,
                 span_if.row_y, span_if.start_x);
        mismatch_cnt++;
      end else begin
        want = pending_spans.pop_front();
        cmp("row_y",    want.row_y,    span_if.row_y);
        cmp("start_x",  want.start_x,  span_if.start_x);
        cmp("fg_mask",  want.fg_mask,  span_if.fg_mask);
        cmp("bg_mask",  want.bg_mask,  span_if.bg_mask);
        cmp("fg_value", want.fg_value, span_if.fg_value);
        cmp("bg_value", want.bg_value, span_if.bg_value);
        cmp("last",     want.last,     span_if.last);
      end
    end
  end

  // Span receiver: random stalls, quiet stretches and two long hold-offs
  initial begin : span_sink
    int  stall;
    int  spans_taken;
    bit  rx_burst;
    spans_taken = 0;
    rx_burst    = 1'b0;
    span_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (spans_taken % 40 == 0) rx_burst = ($urandom_range(2) == 0);
      if (spans_taken == 300 || spans_taken == 2000) stall = HOLD_CYCLES;
      else stall = rx_burst ? 0 : $urandom_range(8);
      if (stall > 0) begin
        span_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      span_if.ready <= 1'b1;
      do @(posedge clk_i); while (!span_if.valid);
      spans_taken++;
      @(negedge clk_i);
    end
  end

  initial begin : watchdog
    #RUN_LIMIT;
    $display("glyph_span_renderer_test failed");
    $finish;
  end

  initial begin : stimulus
    glyph_item_t it;
    logic [7:0]  code, bits, fresh_code;
    bit          fresh_ok;
    int          g, r, k, pick, start, r0, x, waited;
    logic [7:0]  preload [4];
    preload = '{8'h00, 8'hFF, 8'h55, 8'hAA};
    fresh_ok   = 1'b0;
    fresh_code = '0;
    item_if.valid = 1'b0;
    drive_fields('0);
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Fill the glyphs the directed table draws
    for (g = 0; g < 4; g++) begin
      for (r = 0; r < GLYPH_ROWS; r++) begin
        case (preload[g])
          8'h00:   bits = 8'h00;
          8'hFF:   bits = 8'hFF;
          8'h55:   bits = (r < 8) ? (8'h80 >> r) : (8'h01 << (r - 8));
          default: bits = 8'(r * 8'h11);
        endcase
        send_item(load_item(preload[g], r[3:0], bits), NO_PIN);
      end
    end

    for (k = 0; k < DIR_LEN; k++) send_item(DIR_TAB[k].it, DIR_TAB[k].pin);

    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 62) begin
        if (fresh_ok && $urandom_range(1) == 1) code = fresh_code;
        else code = drawable_q[$urandom_range(drawable_q.size() - 1)];
        fresh_ok = 1'b0;
        it      = load_item(code, 4'($urandom_range(15)), 8'($urandom_range(255)));
        it.kind = KIND_DRAW;
        case ($urandom_range(3))
          0:       x = $urandom_range(40) - 32;
          1:       x = $urandom_range(650, 620);
          default: x = $urandom_range(1055) - 32;
        endcase
        it.px = x[10:0];
        case ($urandom_range(3))
          0:       x = $urandom_range(72) - 64;
          1:       x = $urandom_range(490, 460);
          default: x = $urandom_range(1087) - 64;
        endcase
        it.py = x[10:0];
        it.fg = ($urandom_range(7) == 0) ? 8'd0 : 8'($urandom_range(255));
        send_item(it, NO_PIN);
      end else if (pick < 80) begin
        send_item(load_item(8'($urandom_range(255)), 4'($urandom_range(15)),
                            8'($urandom_range(255))), NO_PIN);
      end else begin
        // whole glyph, rows in rotated order; the next draw may pick it
        code = 8'($urandom_range(255));
        r0   = $urandom_range(15);
        for (r = 0; r < GLYPH_ROWS; r++) begin
          x = (r0 + r) % GLYPH_ROWS;
          send_item(load_item(code, x[3:0], 8'($urandom_range(255))), NO_PIN);
        end
        fresh_code = code;
        fresh_ok   = 1'b1;
      end
    end
    item_if.valid <= 1'b0;

    waited = 0;
    while (pending_spans.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_spans.size() != 0) begin
      $display("%0t: %0d spans never arrived", $time, pending_spans.size());
      mismatch_cnt++;
    end
    repeat (DRAIN_TAIL) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("glyph_span_renderer_test passed");
    end else begin
      $display("glyph_span_renderer_test failed");
    end
    $finish;
  end

endmodule
